// ===== rtl/core/oqkr_pkg.sv =====
package oqkr_pkg;

    localparam int DEPTH    = 16;
    localparam int ID_BITS  = 16;
    localparam int REF_BITS = 16;

    // Fixed widths of the stream fields
    localparam int CMD_W     = 3;
    localparam int ID_FW     = 16;
    localparam int REF_FW    = 16;
    localparam int COUNT_FW  = 5;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CMP_W   = CNT_W + 1;
    localparam int ENTRY_W = ID_BITS + REF_BITS;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND    = 3'd0,
        CMD_TAKE_HEAD = 3'd1,
        CMD_TAKE_TAIL = 3'd2,
        CMD_REMOVE    = 3'd3,
        CMD_FIND      = 3'd4
    } cmd_t;

    typedef struct packed {
        logic                found;
        logic [REF_BITS-1:0] ref_val;
        logic [ID_BITS-1:0]  id_val;
        logic [CNT_W-1:0]    count;
        logic                rejected;
    } result_t;

endpackage

// ===== rtl/core/ordered_queue_with_key_removal.sv =====
// Ordered store of up to DEPTH (id, ref) entries kept in insertion order.
// Slave stream carries one command per beat: append at tail, take head,
// take tail, remove first entry with matching id, or find it in place.
// Master stream returns exactly one beat per command: found flag, the
// entry's ref and id (zero when nothing taken or found), the entry count
// after the command, and a rejected flag for an append to a full store.
// Entries live in a single-port-write, registered-read RAM; one sequencer
// walks it a slot per cycle, comparing ids and moving entries down to close
// the gap left by a removal.
// Append, unused codes and any take or search on an empty store go from
// idle straight to the result; take tail reads only the last slot, a
// search or removal checks slots in order from the head, and a removal then
// moves each entry behind the hit down a slot. s_tready stays low while a
// command is in work. The result sits in an output register, so a new
// command is taken while the previous result waits; the sequencer holds
// its finished result until that register frees up. Reset empties the
// store (count zero); stored entries themselves are not cleared.
module ordered_queue_with_key_removal (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [2:0] cmd, [18:3] entry_id, [34:19] entry_ref, rest zero
    input  logic [oqkr_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] found, [16:1] out_ref, [32:17] out_id, [37:33] entry_count,
    // [38] rejected, rest zero
    output logic [oqkr_pkg::M_TDATA_W-1:0]     m_tdata
);

    localparam int ID_LO    = oqkr_pkg::CMD_W;
    localparam int REF_LO   = ID_LO + oqkr_pkg::ID_FW;
    localparam int O_REF_LO = 1;
    localparam int O_ID_LO  = O_REF_LO + oqkr_pkg::REF_FW;
    localparam int O_CNT_LO = O_ID_LO + oqkr_pkg::ID_FW;
    localparam int O_REJ    = O_CNT_LO + oqkr_pkg::COUNT_FW;

    logic [oqkr_pkg::CMD_W-1:0]    s_cmd;
    logic [oqkr_pkg::ID_FW-1:0]    s_entry_id;
    logic [oqkr_pkg::REF_FW-1:0]   s_entry_ref;
    logic                          res_valid;
    logic                          res_ready;
    oqkr_pkg::result_t             res;
    logic                          m_tvalid_reg;
    logic                          m_tvalid_next;
    logic [oqkr_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [oqkr_pkg::M_TDATA_W-1:0] m_tdata_next;

    assign s_cmd       = s_tdata[oqkr_pkg::CMD_W-1:0];
    assign s_entry_id  = s_tdata[REF_LO-1:ID_LO];
    assign s_entry_ref = s_tdata[REF_LO+oqkr_pkg::REF_FW-1:REF_LO];

    oqkr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_cmd),
        .in_id     (s_entry_id[oqkr_pkg::ID_BITS-1:0]),
        .in_ref    (s_entry_ref[oqkr_pkg::REF_BITS-1:0]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tdata_next = '0;
        m_tdata_next[0] = res.found;
        m_tdata_next[O_ID_LO-1:O_REF_LO] = oqkr_pkg::REF_FW'(res.ref_val);
        m_tdata_next[O_CNT_LO-1:O_ID_LO] = oqkr_pkg::ID_FW'(res.id_val);
        m_tdata_next[O_REJ-1:O_CNT_LO]   = oqkr_pkg::COUNT_FW'(res.count);
        m_tdata_next[O_REJ]              = res.rejected;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        if (res_valid && res_ready) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // One command in work at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command accepted while another is in work");

    // A dropped append never reports an entry and only happens when full
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[O_REJ] |->
            !m_tdata[0] &&
            (m_tdata[O_REJ-1:O_CNT_LO] == oqkr_pkg::COUNT_FW'(oqkr_pkg::DEPTH)))
        else $error("rejected beat with found set or store not full");

    // Count never exceeds the store depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |->
            (m_tdata[O_REJ-1:O_CNT_LO] <= oqkr_pkg::COUNT_FW'(oqkr_pkg::DEPTH)))
        else $error("entry count beyond depth");

    // A finished result is handed over as soon as the output register frees
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !m_tvalid_reg |=> m_tvalid_reg)
        else $error("result not moved into free output register");

endmodule

// ===== rtl/core/oqkr_ram.sv =====
module oqkr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/oqkr_ctrl.sv =====
module oqkr_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [oqkr_pkg::CMD_W-1:0]      in_cmd,
    input  logic [oqkr_pkg::ID_BITS-1:0]    in_id,
    input  logic [oqkr_pkg::REF_BITS-1:0]   in_ref,
    output logic                            res_valid,
    input  logic                            res_ready,
    output oqkr_pkg::result_t               res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SHIFT,
        ST_DONE
    } state_t;

    state_t                          state_reg;
    oqkr_pkg::cmd_t                  cmd_reg;
    logic [oqkr_pkg::ID_BITS-1:0]    key_reg;
    logic [oqkr_pkg::ADDR_W-1:0]     idx_reg;
    logic [oqkr_pkg::CNT_W-1:0]      count_reg;
    logic                            found_reg;
    logic [oqkr_pkg::ID_BITS-1:0]    res_id_reg;
    logic [oqkr_pkg::REF_BITS-1:0]   res_ref_reg;
    logic                            rejected_reg;

    oqkr_pkg::cmd_t                  cmd_in;
    logic [oqkr_pkg::CMP_W-1:0]      idx_ext;
    logic [oqkr_pkg::CMP_W-1:0]      count_ext;
    logic [oqkr_pkg::ADDR_W-1:0]     rd_addr;
    logic [oqkr_pkg::ADDR_W-1:0]     wr_addr;
    logic [oqkr_pkg::ENTRY_W-1:0]    wr_data;
    logic [oqkr_pkg::ENTRY_W-1:0]    rd_data;
    logic                            wr_en;
    logic [oqkr_pkg::ID_BITS-1:0]    rd_id;
    logic [oqkr_pkg::REF_BITS-1:0]   rd_ref;
    logic                            hit_now;
    logic                            removing;
    logic                            full;
    logic                            empty;

    assign cmd_in    = oqkr_pkg::cmd_t'(in_cmd);
    assign idx_ext   = oqkr_pkg::CMP_W'(idx_reg);
    assign count_ext = oqkr_pkg::CMP_W'(count_reg);
    assign full      = (count_ext == oqkr_pkg::CMP_W'(oqkr_pkg::DEPTH));
    assign empty     = (count_reg == '0);

    assign rd_id  = rd_data[oqkr_pkg::ENTRY_W-1:oqkr_pkg::REF_BITS];
    assign rd_ref = rd_data[oqkr_pkg::REF_BITS-1:0];

    // take commands hit on the addressed slot, searches compare the key
    assign hit_now  = (cmd_reg == oqkr_pkg::CMD_TAKE_HEAD) ||
                      (cmd_reg == oqkr_pkg::CMD_TAKE_TAIL) ||
                      (rd_id == key_reg);
    assign removing = (cmd_reg == oqkr_pkg::CMD_TAKE_HEAD) ||
                      (cmd_reg == oqkr_pkg::CMD_REMOVE);

    // Read address runs one slot ahead of the check position, two ahead of the shift position
    always_comb begin
        rd_addr = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_in == oqkr_pkg::CMD_TAKE_TAIL) begin
                    rd_addr = oqkr_pkg::ADDR_W'(count_ext - 1'b1);
                end
            end
            ST_CHECK: rd_addr = oqkr_pkg::ADDR_W'(idx_ext + 1'b1);
            ST_SHIFT: rd_addr = oqkr_pkg::ADDR_W'(idx_ext + 2'd2);
            default:  rd_addr = '0;
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = rd_data;
        if (state_reg == ST_IDLE) begin
            wr_en   = in_valid && (cmd_in == oqkr_pkg::CMD_APPEND) && !full;
            wr_addr = oqkr_pkg::ADDR_W'(count_ext);
            wr_data = {in_id, in_ref};
        end else if (state_reg == ST_SHIFT) begin
            wr_en = 1'b1;
        end
    end

    oqkr_ram #(
        .WIDTH (oqkr_pkg::ENTRY_W),
        .DEPTH (oqkr_pkg::DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            cmd_reg      <= oqkr_pkg::CMD_APPEND;
            idx_reg      <= '0;
            found_reg    <= 1'b0;
            rejected_reg <= 1'b0;
            res_id_reg   <= '0;
            res_ref_reg  <= '0;
            key_reg      <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        cmd_reg      <= cmd_in;
                        key_reg      <= in_id;
                        idx_reg      <= rd_addr;
                        found_reg    <= 1'b0;
                        rejected_reg <= 1'b0;
                        res_id_reg   <= '0;
                        res_ref_reg  <= '0;
                        state_reg    <= ST_DONE;
                        case (cmd_in) inside
                            oqkr_pkg::CMD_APPEND: begin
                                if (full) begin
                                    rejected_reg <= 1'b1;
                                end else begin
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            oqkr_pkg::CMD_TAKE_HEAD, oqkr_pkg::CMD_TAKE_TAIL,
                            oqkr_pkg::CMD_REMOVE, oqkr_pkg::CMD_FIND: begin
                                if (!empty) begin
                                    state_reg <= ST_CHECK;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_CHECK: begin
                    if (hit_now) begin
                        found_reg   <= 1'b1;
                        res_id_reg  <= rd_id;
                        res_ref_reg <= rd_ref;
                        if (removing && (idx_ext + 1'b1 < count_ext)) begin
                            state_reg <= ST_SHIFT;
                        end else begin
                            if (removing || cmd_reg == oqkr_pkg::CMD_TAKE_TAIL) begin
                                count_reg <= count_reg - 1'b1;
                            end
                            state_reg <= ST_DONE;
                        end
                    end else if (idx_ext + 1'b1 < count_ext) begin
                        idx_reg <= idx_reg + 1'b1;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_SHIFT: begin
                    // slot idx takes the entry behind it
                    idx_reg <= idx_reg + 1'b1;
                    if (!(idx_ext + 2'd2 < count_ext)) begin
                        count_reg <= count_reg - 1'b1;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign res_valid    = (state_reg == ST_DONE);
    assign res.found    = found_reg;
    assign res.ref_val  = res_ref_reg;
    assign res.id_val   = res_id_reg;
    assign res.count    = count_reg;
    assign res.rejected = rejected_reg;

endmodule
